### design/hsfp_pkg.sv
// Package for the five-point heat stencil: register codes, field widths and
// fixed-point constants used by the stencil.
// Depends on nothing.
package hsfp_pkg;

   typedef enum logic [1:0] {
      CSR_ROW_LENGTH = 2'd0,
      CSR_ROW_TOTAL  = 2'd1,
      CSR_COEF_X     = 2'd2,
      CSR_COEF_Y     = 2'd3
   } csr_index_type;

   localparam int TempW   = 32;
   localparam int CoefW   = 16;
   localparam int LenRegW = 11;
   localparam int RowsW   = 16;
   localparam int FracW   = 16;
   localparam int DiffW   = TempW + 3;
   localparam int ProdW   = DiffW + CoefW + 1;
   localparam int AccW    = ProdW + 1;
   localparam int DeltaW  = AccW - FracW;
   localparam int SumW    = DeltaW + 1;

   localparam int MinLen         = 3;
   localparam int MinRows        = 3;
   localparam int RowLengthReset = 1024;
   localparam int RowTotalReset  = 1024;

   localparam logic signed [AccW-1:0] RoundHalf =
      {{(AccW-FracW){1'b0}}, 1'b1, {(FracW-1){1'b0}}};
   localparam logic signed [SumW-1:0] TempMax =
      {{(SumW-TempW+1){1'b0}}, {(TempW-1){1'b1}}};
   localparam logic signed [SumW-1:0] TempMin =
      {{(SumW-TempW+1){1'b1}}, {(TempW-1){1'b0}}};

endpackage

### design/heat_stencil_five_point.sv
// Five-point stencil for one explicit Euler step of the 2-D heat equation.
// Depends on hsfp_pkg.
//
// Channel    Dir  Handshake             Payload
// req_       in   req_tvalid/tready     tdata: in_temp
// rsp_       out  rsp_tvalid/tready     tdata: new_temp, tlast: last_point
// csr_       in   csr_we                csr_index, csr_wdata
//
// One sample is taken per cycle while req_tready is high; the line stores are read and
// written once per sample, which sets that figure. A result passes through each stage
// register and the output register after the sample that completes its neighbourhood.
// Reset clears the counters, the window and the pipeline; the line stores hold nothing
// valid until rows have passed. A stalled result side fills the pipeline stages before req_tready drops.
module heat_stencil_five_point #(
   parameter int MAX_ROW_LEN = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [31:0]                  req_tdata,   // [31:0] in_temp
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [31:0]                  rsp_tdata,   // [31:0] new_temp
   output logic                         rsp_tlast,
   input  logic                         csr_we,
   input  hsfp_pkg::csr_index_type      csr_index,
   input  logic [15:0]                  csr_wdata
);
   import hsfp_pkg::*;

   localparam int ColW = $clog2(MAX_ROW_LEN);
   localparam int CmpW = (LenRegW > ColW + 1) ? LenRegW : ColW + 1;
   localparam int ResetLen = (RowLengthReset > MAX_ROW_LEN) ? MAX_ROW_LEN : RowLengthReset;
   localparam logic [ColW-1:0]  ResetLenLast  = ColW'(ResetLen - 1);
   localparam logic [RowsW-1:0] ResetRowsLast = RowsW'(RowTotalReset - 1);

   // Configuration.
   logic [ColW-1:0]  len_last_ff, len_last_in;
   logic [RowsW-1:0] rows_last_ff, rows_last_in;
   logic [CoefW-1:0] coef_x_ff, coef_y_ff;
   logic [CmpW-1:0]  len_wide, len_eff;

   always_comb begin
      len_wide = CmpW'(csr_wdata[LenRegW-1:0]);
      if (len_wide < CmpW'(MinLen)) begin
         len_eff = CmpW'(MinLen);
      end else if (len_wide > CmpW'(MAX_ROW_LEN)) begin
         len_eff = CmpW'(MAX_ROW_LEN);
      end else begin
         len_eff = len_wide;
      end
      len_last_in = ColW'(len_eff - CmpW'(1));
      if (csr_wdata < RowsW'(MinRows)) begin
         rows_last_in = RowsW'(MinRows - 1);
      end else begin
         rows_last_in = csr_wdata - RowsW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_last_ff  <= ResetLenLast;
         rows_last_ff <= ResetRowsLast;
         coef_x_ff    <= '0;
         coef_y_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROW_LENGTH: len_last_ff  <= len_last_in;
            CSR_ROW_TOTAL:  rows_last_ff <= rows_last_in;
            CSR_COEF_X:     coef_x_ff    <= csr_wdata;
            CSR_COEF_Y:     coef_y_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline flow control.
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic rsp_free, s4_free, s3_free, s2_free, s1_free, s0_free;
   logic accept, s0_move;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s4_free    = !s4_valid_ff || rsp_free;
   assign s3_free    = !s3_valid_ff || s4_free;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign s0_free    = !s0_valid_ff || s1_free;
   assign req_tready = s0_free;
   assign accept     = req_tvalid && s0_free;
   assign s0_move    = s0_valid_ff && s1_free;

   // Raster position.
   logic [ColW-1:0]  col_ff, col_in;
   logic [RowsW-1:0] row_ff, row_in;
   logic             geom_write, col_end, emit, last;

   assign geom_write = csr_we && (csr_index == CSR_ROW_LENGTH || csr_index == CSR_ROW_TOTAL);
   assign col_end    = (col_ff == len_last_ff);
   assign emit       = (row_ff >= RowsW'(2)) && (col_ff >= ColW'(2));
   assign last       = (row_ff == rows_last_ff) && col_end;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (geom_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = (row_ff == rows_last_ff) ? '0 : row_ff + RowsW'(1);
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage 0: input register and line store reads.
   logic signed [TempW-1:0] s0_temp_ff, upper_rd_ff, middle_rd_ff;
   logic [ColW-1:0]         s0_col_ff;
   logic                    s0_emit_ff, s0_last_ff;
   logic signed [TempW-1:0] upper_mem_ff  [MAX_ROW_LEN];
   logic signed [TempW-1:0] middle_mem_ff [MAX_ROW_LEN];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_free) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_temp_ff <= req_tdata;
         s0_col_ff  <= col_ff;
         s0_emit_ff <= emit;
         s0_last_ff <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_move) begin
         upper_mem_ff[s0_col_ff] <= middle_rd_ff;
      end
      if (accept) begin
         upper_rd_ff <= upper_mem_ff[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s0_move) begin
         middle_mem_ff[s0_col_ff] <= s0_temp_ff;
      end
      if (accept) begin
         middle_rd_ff <= middle_mem_ff[col_ff];
      end
   end

   // Window: only the columns that feed the stencil are kept.
   logic signed [TempW-1:0] win2_ff, win4_ff, win5_ff, win8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win2_ff <= '0;
         win4_ff <= '0;
         win5_ff <= '0;
         win8_ff <= '0;
      end else if (s0_move) begin
         win2_ff <= upper_rd_ff;
         win4_ff <= win5_ff;
         win5_ff <= middle_rd_ff;
         win8_ff <= s0_temp_ff;
      end
   end

   // Stage 1: stencil operands.
   logic signed [TempW-1:0] s1_up_ff, s1_left_ff, s1_mid_ff, s1_right_ff, s1_down_ff;
   logic                    s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= s0_valid_ff && s0_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_up_ff    <= win2_ff;
         s1_left_ff  <= win4_ff;
         s1_mid_ff   <= win5_ff;
         s1_right_ff <= middle_rd_ff;
         s1_down_ff  <= win8_ff;
         s1_last_ff  <= s0_last_ff;
      end
   end

   // Stage 2: second differences.
   logic signed [DiffW-1:0] s2_dxx_ff, s2_dyy_ff;
   logic signed [TempW-1:0] s2_mid_ff;
   logic                    s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_dxx_ff  <= DiffW'(s1_up_ff) - (DiffW'(s1_mid_ff) <<< 1) + DiffW'(s1_down_ff);
         s2_dyy_ff  <= DiffW'(s1_left_ff) - (DiffW'(s1_mid_ff) <<< 1) + DiffW'(s1_right_ff);
         s2_mid_ff  <= s1_mid_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // Stage 3: products with the coefficients.
   logic signed [CoefW:0]   coef_x_s, coef_y_s;
   logic signed [ProdW-1:0] s3_px_ff, s3_py_ff;
   logic signed [TempW-1:0] s3_mid_ff;
   logic                    s3_last_ff;

   assign coef_x_s = $signed({1'b0, coef_x_ff});
   assign coef_y_s = $signed({1'b0, coef_y_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_free) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_free) begin
         s3_px_ff   <= ProdW'(s2_dxx_ff) * ProdW'(coef_x_s);
         s3_py_ff   <= ProdW'(s2_dyy_ff) * ProdW'(coef_y_s);
         s3_mid_ff  <= s2_mid_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // Stage 4: sum and round half up to Q16.16.
   logic signed [AccW-1:0]   acc;
   logic signed [DeltaW-1:0] s4_delta_ff;
   logic signed [TempW-1:0]  s4_mid_ff;
   logic                     s4_last_ff;

   assign acc = AccW'(s3_px_ff) + AccW'(s3_py_ff) + RoundHalf;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_free) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_free) begin
         s4_delta_ff <= acc[AccW-1:FracW];
         s4_mid_ff   <= s3_mid_ff;
         s4_last_ff  <= s3_last_ff;
      end
   end

   // Output register: add to the centre and saturate.
   logic signed [SumW-1:0]  sum;
   logic signed [TempW-1:0] sat;
   logic [TempW-1:0]        rsp_data_ff;
   logic                    rsp_last_ff;

   always_comb begin
      sum = SumW'(s4_mid_ff) + SumW'(s4_delta_ff);
      if (sum > TempMax) begin
         sat = TempW'(TempMax);
      end else if (sum < TempMin) begin
         sat = TempW'(TempMin);
      end else begin
         sat = sum[TempW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         rsp_data_ff <= sat;
         rsp_last_ff <= s4_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### design/hsfp_checker.sv
// Port-level checks for the five-point heat stencil, bound to its top level.
// Depends on heat_stencil_five_point.
module hsfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result keeps its value and its last-point flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // When the result side can move, every stage can move, so a request can be taken.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("request refused while the output was free");

   // A result never appears straight out of reset.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(reset))
      else $error("result appeared straight out of reset");

endmodule

bind heat_stencil_five_point hsfp_checker u_hsfp_checker (.*);
